// ----- rtl/ecpf_pkg.sv -----
// Shared types, constants and arithmetic helpers for the ESC command block.
`default_nettype none
package ecpf_pkg;

	// Number of motors that hold a stored width.
	localparam int MOTOR_COUNT = 2;
	// Raw throttle values and drive fields carried in each beat.
	localparam int NUM_RAW = 2;
	localparam int MIDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

	localparam int WIDTH_W = 15;
	localparam int COUNT_W = 16;
	localparam int RAW_W = 14;
	localparam int PROD_W = 29;
	localparam int SUM_W = 18;

	// Reset values of the configuration registers.
	localparam logic [WIDTH_W-1:0] RST_MIN = 15'd1000;
	localparam logic [WIDTH_W-1:0] RST_MAX = 15'd2000;
	localparam logic [WIDTH_W-1:0] RST_NEUTRAL = 15'd1500;
	localparam logic [COUNT_W-1:0] RST_TIMEOUT = 16'd500;

	// Divisor of the linear map: the full span of the raw range.
	localparam logic [15:0] RAW_SPAN = 16'd16383;

	typedef enum logic [1:0] {
		CMD_ESC = 2'd0,
		CMD_SET = 2'd1,
		CMD_TICK = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		REG_MIN = 2'd0,
		REG_MAX = 2'd1,
		REG_NEUTRAL = 2'd2,
		REG_TIMEOUT = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [WIDTH_W-1:0] pulse_min;
		logic [WIDTH_W-1:0] pulse_max;
		logic [WIDTH_W-1:0] pulse_neutral;
		logic [COUNT_W-1:0] timeout_ms;
	} cfg_t;

	typedef struct packed {
		cmd_t command;
		logic signed [RAW_W-1:0] raw_cmd_0;
		logic signed [RAW_W-1:0] raw_cmd_1;
		logic [7:0] command_count;
		logic [7:0] motor_sel;
		logic [15:0] pulse_value;
	} item_t;

	// Item plus the quotient magnitude and sign of the map for each raw value.
	typedef struct packed {
		item_t item;
		logic [NUM_RAW-1:0][WIDTH_W-1:0] quot;
		logic span_neg;
	} map_t;

	typedef struct packed {
		logic [NUM_RAW-1:0][WIDTH_W-1:0] drive;
		logic is_armed;
		logic [WIDTH_W-1:0] read_width;
		logic [COUNT_W-1:0] since_command;
	} result_t;

	// Quotient of a / 16383. With q0 = a >> 14 the remainder a - 16383*q0 equals
	// low14(a) + q0, which stays below four divisors, so at most three corrections.
	function automatic logic [WIDTH_W-1:0] div_span(input logic [PROD_W-1:0] a);
		logic [WIDTH_W-1:0] q0;
		logic [15:0] rem;
		logic [1:0] corr;
		q0 = a[PROD_W-1:14];
		rem = {2'b00, a[13:0]} + {1'b0, q0};
		if (rem >= 16'(3 * RAW_SPAN)) corr = 2'd3;
		else if (rem >= 16'(2 * RAW_SPAN)) corr = 2'd2;
		else if (rem >= RAW_SPAN) corr = 2'd1;
		else corr = 2'd0;
		return q0 + {13'd0, corr};
	endfunction

	// Low bound wins first, then the high bound.
	function automatic logic [WIDTH_W-1:0] clamp_width(
		input logic signed [SUM_W-1:0] v,
		input logic [WIDTH_W-1:0] lo,
		input logic [WIDTH_W-1:0] hi
	);
		logic [WIDTH_W-1:0] res;
		if (v < $signed({3'b000, lo})) res = lo;
		else if (v > $signed({3'b000, hi})) res = hi;
		else res = v[WIDTH_W-1:0];
		return res;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/ecpf_cfg.sv -----
// APB register file holding the pulse bounds, neutral width and timeout.
`default_nettype none
module ecpf_cfg
	import ecpf_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [3:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	output cfg_t cfg
);

	cfg_t cfg_q;
	reg_idx_t idx;
	logic wr_en;

	assign pready = 1'b1;
	assign idx = reg_idx_t'(paddr[3:2]);
	assign wr_en = psel && penable && pwrite;
	assign cfg = cfg_q;

	// Register writes in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pulse_min <= RST_MIN;
			cfg_q.pulse_max <= RST_MAX;
			cfg_q.pulse_neutral <= RST_NEUTRAL;
			cfg_q.timeout_ms <= RST_TIMEOUT;
		end else if (wr_en) begin
			case (idx)
				REG_MIN: cfg_q.pulse_min <= pwdata[WIDTH_W-1:0];
				REG_MAX: cfg_q.pulse_max <= pwdata[WIDTH_W-1:0];
				REG_NEUTRAL: cfg_q.pulse_neutral <= pwdata[WIDTH_W-1:0];
				REG_TIMEOUT: cfg_q.timeout_ms <= pwdata[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back.
	always_comb begin
		case (idx)
			REG_MIN: prdata = {17'd0, cfg_q.pulse_min};
			REG_MAX: prdata = {17'd0, cfg_q.pulse_max};
			REG_NEUTRAL: prdata = {17'd0, cfg_q.pulse_neutral};
			REG_TIMEOUT: prdata = {16'd0, cfg_q.timeout_ms};
			default: prdata = 32'd0;
		endcase
	end

endmodule
`default_nettype wire

// ----- rtl/ecpf_map.sv -----
// Three-stage pipeline that maps raw throttle values onto the pulse range.
`default_nettype none
module ecpf_map
	import ecpf_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire cfg_t cfg,
	input wire logic in_valid,
	output logic in_ready,
	input wire item_t in_item,
	output logic out_valid,
	input wire logic out_ready,
	output map_t out_map
);

	logic v_s1, v_s2, v_s3;
	logic en1, en2, en3;
	item_t item_s1, item_s2, item_s3;
	logic neg_s2, neg_s3;
	logic [NUM_RAW-1:0][PROD_W-1:0] prod_s2;
	logic [NUM_RAW-1:0][WIDTH_W-1:0] quot_s3;

	logic [15:0] span;
	logic [WIDTH_W-1:0] span_abs;
	logic [NUM_RAW-1:0][RAW_W-1:0] offset;
	logic [NUM_RAW-1:0][PROD_W-1:0] prod;

	// Each stage moves when it is empty or the next one moves.
	assign en3 = !v_s3 || out_ready;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	// Offset raw value (raw + 8192 is the raw value with its sign bit flipped)
	// times the magnitude of the span.
	always_comb begin
		span = {1'b0, cfg.pulse_max} - {1'b0, cfg.pulse_min};
		span_abs = span[15] ? WIDTH_W'(-span) : span[WIDTH_W-1:0];
		offset[0] = {~item_s1.raw_cmd_0[RAW_W-1], item_s1.raw_cmd_0[RAW_W-2:0]};
		offset[1] = {~item_s1.raw_cmd_1[RAW_W-1], item_s1.raw_cmd_1[RAW_W-2:0]};
		for (int k = 0; k < NUM_RAW; k++) begin
			prod[k] = PROD_W'(offset[k]) * PROD_W'(span_abs);
		end
	end

	// Payload registers of the three stages.
	always_ff @(posedge clk) begin
		if (en1) item_s1 <= in_item;
		if (en2) begin
			item_s2 <= item_s1;
			prod_s2 <= prod;
			neg_s2 <= span[15];
		end
		if (en3) begin
			item_s3 <= item_s2;
			neg_s3 <= neg_s2;
			for (int k = 0; k < NUM_RAW; k++) begin
				quot_s3[k] <= div_span(prod_s2[k]);
			end
		end
	end

	assign out_valid = v_s3;
	assign out_map.item = item_s3;
	assign out_map.quot = quot_s3;
	assign out_map.span_neg = neg_s3;

endmodule
`default_nettype wire

// ----- rtl/ecpf_state.sv -----
// Motor state update (widths, armed flag, tick count) and the result register.
`default_nettype none
module ecpf_state
	import ecpf_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire cfg_t cfg,
	input wire logic in_valid,
	output logic in_ready,
	input wire map_t in_map,
	output logic out_valid,
	input wire logic out_ready,
	output result_t out_res
);

	logic armed_q, armed_n;
	logic [MOTOR_COUNT-1:0][WIDTH_W-1:0] width_q, width_n;
	logic [COUNT_W-1:0] elapsed_q, elapsed_n, elapsed_inc;
	logic out_v_q;
	result_t res_q, res_n;
	logic en_out, fire;
	logic idx_ok;
	logic [MIDX_W-1:0] idx_sel;
	logic [NUM_RAW-1:0][WIDTH_W-1:0] mapped;
	logic [WIDTH_W-1:0] set_width;
	logic signed [SUM_W-1:0] sum;
	item_t it;

	assign it = in_map.item;
	assign en_out = !out_v_q || out_ready;
	assign in_ready = en_out;
	assign fire = in_valid && en_out;
	assign idx_ok = it.motor_sel < 8'(MOTOR_COUNT);
	assign idx_sel = it.motor_sel[MIDX_W-1:0];
	assign elapsed_inc = (elapsed_q != '1) ? elapsed_q + 16'd1 : elapsed_q;

	// Finish the map: add or subtract the quotient from the low bound, then clamp.
	always_comb begin
		for (int k = 0; k < NUM_RAW; k++) begin
			if (in_map.span_neg) begin
				sum = $signed({3'b000, cfg.pulse_min}) - $signed({3'b000, in_map.quot[k]});
			end else begin
				sum = $signed({3'b000, cfg.pulse_min}) + $signed({3'b000, in_map.quot[k]});
			end
			mapped[k] = clamp_width(sum, cfg.pulse_min, cfg.pulse_max);
		end
		set_width = clamp_width($signed({2'b00, it.pulse_value}), cfg.pulse_min,
			cfg.pulse_max);
	end

	// Next state for the item at the head of the map pipeline.
	always_comb begin
		armed_n = armed_q;
		width_n = width_q;
		elapsed_n = elapsed_q;
		case (it.command)
			CMD_ESC: begin
				for (int i = 0; i < MOTOR_COUNT; i++) begin
					if (8'(i) < it.command_count) width_n[i] = mapped[i];
				end
				armed_n = 1'b1;
				elapsed_n = '0;
			end
			CMD_SET: begin
				if (idx_ok) begin
					width_n[idx_sel] = set_width;
					elapsed_n = '0;
				end
			end
			CMD_TICK: begin
				elapsed_n = elapsed_inc;
				if (armed_q && (elapsed_inc > cfg.timeout_ms)) begin
					armed_n = 1'b0;
					for (int i = 0; i < MOTOR_COUNT; i++) width_n[i] = cfg.pulse_neutral;
				end
			end
			default: ;
		endcase
	end

	// Result fields after the update.
	always_comb begin
		for (int d = 0; d < NUM_RAW; d++) res_n.drive[d] = cfg.pulse_neutral;
		for (int i = 0; i < MOTOR_COUNT; i++) begin
			if (armed_n) res_n.drive[i] = width_n[i];
		end
		res_n.is_armed = armed_n;
		res_n.read_width = idx_ok ? width_n[idx_sel] : cfg.pulse_neutral;
		res_n.since_command = elapsed_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= 1'b0;
			elapsed_q <= '0;
			out_v_q <= 1'b0;
			for (int i = 0; i < MOTOR_COUNT; i++) width_q[i] <= RST_NEUTRAL;
		end else begin
			if (en_out) out_v_q <= in_valid;
			if (fire) begin
				armed_q <= armed_n;
				elapsed_q <= elapsed_n;
				width_q <= width_n;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (fire) res_q <= res_n;
	end

	assign out_valid = out_v_q;
	assign out_res = res_q;

	// The block disarms only on a millisecond tick.
	a_disarm_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(armed_q) |-> $past(fire && it.command == CMD_TICK))
		else $error("disarm without a tick");

	// The block arms only on an ESC command.
	a_arm_on_esc: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(armed_q) |-> $past(fire && it.command == CMD_ESC))
		else $error("arm without an ESC command");

	// A tick below saturation advances the count by exactly one.
	a_tick_count: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && it.command == CMD_TICK && elapsed_q != '1)
		|=> elapsed_q == $past(elapsed_q) + 16'd1)
		else $error("tick count did not advance");

	// A result leaves only with the flag it was computed with.
	a_result_armed: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> res_q.is_armed == armed_q)
		else $error("result armed flag differs from state");

endmodule
`default_nettype wire

// ----- rtl/esc_command_pwm_failsafe_top.sv -----
// Top level of the ESC command block with failsafe timeout.
//
// Input stream (s_*): one beat carries a command in tuser and its operands in
// tdata. Output stream (m_*): exactly one result beat per input beat, in order,
// showing the drive widths, armed flag, read-back width and tick count after
// the item has been applied.
// Each beat passes the three map stages and then the result register before
// its result is valid on m_tdata. Throughput: one beat per cycle while
// m_tready is high. The map runs in a three-stage pipeline (input register,
// offset times span, divide by 16383); add and clamp go with the state update
// ahead of the result register. The only loop is the registered state update,
// so items follow each other in consecutive cycles.
// Stalls: when m_tready is low the result register holds; earlier stages keep
// accepting beats until the pipeline is full, then s_tready drops.
// Reset: arst_n clears the pipeline and the result valid, disarms, clears the
// tick count, loads every stored width with 1500 us and the registers with
// their reset values (min 1000, max 2000, neutral 1500, timeout 500 ms).
// Configuration: APB writes at 0x0 min, 0x4 max, 0x8 neutral, 0xC timeout; the
// user must issue them only while no beat is in flight, the block does not enforce it.
`default_nettype none
module esc_command_pwm_failsafe_top
	import ecpf_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	// APB configuration port.
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [3:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	// Input stream.
	input wire logic s_tvalid,
	output logic s_tready,
	// raw_cmd_0[13:0], raw_cmd_1[27:14], command_count[35:28],
	// motor_sel[43:36], pulse_value[59:44], zero fill [63:60]
	input wire logic [63:0] s_tdata,
	// command[1:0]
	input wire logic [1:0] s_tuser,
	// Output stream.
	output logic m_tvalid,
	input wire logic m_tready,
	// drive_0[14:0], drive_1[29:15], is_armed[30], read_width[45:31],
	// since_command[61:46], zero fill [63:62]
	output logic [63:0] m_tdata
);

	cfg_t cfg;
	item_t in_item;
	map_t map_beat;
	logic map_valid, map_ready;
	result_t res;

	assign in_item.command = cmd_t'(s_tuser);
	assign in_item.raw_cmd_0 = s_tdata[13:0];
	assign in_item.raw_cmd_1 = s_tdata[27:14];
	assign in_item.command_count = s_tdata[35:28];
	assign in_item.motor_sel = s_tdata[43:36];
	assign in_item.pulse_value = s_tdata[59:44];

	ecpf_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	ecpf_map u_map (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_item(in_item),
		.out_valid(map_valid),
		.out_ready(map_ready),
		.out_map(map_beat)
	);

	ecpf_state u_state (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.in_valid(map_valid),
		.in_ready(map_ready),
		.in_map(map_beat),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_res(res)
	);

	assign m_tdata = {2'b00, res.since_command, res.read_width, res.is_armed,
		res.drive[1], res.drive[0]};

endmodule
`default_nettype wire
